FILE: src/bal_pkg.sv
package bal_pkg;

  localparam int QuadNodes = 16;
  localparam int NodeBits  = 4;
  localparam int CoefBits  = 24;
  localparam int CoefW     = 26;
  localparam int DiffW     = 33;
  localparam int ProdW     = 60;
  localparam int SumW      = 64;
  localparam int MagW      = 34;
  localparam int SqW       = 69;
  localparam int RootW     = 35;
  localparam int SqrtSteps = 35;
  localparam int WeightW   = 22;
  localparam int WProdW    = 57;
  localparam int AccW      = 64;
  localparam int OutW      = 36;

  localparam logic [SumW-1:0] RoundHalf = 64'd1 << (CoefBits - 1);
  localparam logic [AccW-1:0] OutRound  = 64'd1 << CoefBits;
  localparam logic [OutW-1:0] OutMax    = {OutW{1'b1}};
  localparam logic [NodeBits-1:0] LastNode = NodeBits'(QuadNodes - 1);

  typedef struct packed {
    logic                vld;
    logic [NodeBits-1:0] node;
  } tag_t;

  typedef struct packed {
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] c;
  } coef_t;

  // Gauss-Legendre nodes, Q0.24
  function automatic logic signed [31:0] node_x(input logic [NodeBits-1:0] i);
    logic signed [31:0] r;
    unique case (i)
      4'd0:  r = -32'sd16599393;
      4'd1:  r = -32'sd15847339;
      4'd2:  r = -32'sd14522882;
      4'd3:  r = -32'sd12673583;
      4'd4:  r = -32'sd10366243;
      4'd5:  r = -32'sd7684246;
      4'd6:  r = -32'sd4724524;
      4'd7:  r = -32'sd1594045;
      4'd8:  r = 32'sd1594045;
      4'd9:  r = 32'sd4724524;
      4'd10: r = 32'sd7684246;
      4'd11: r = 32'sd10366243;
      4'd12: r = 32'sd12673583;
      4'd13: r = 32'sd14522882;
      4'd14: r = 32'sd15847339;
      4'd15: r = 32'sd16599393;
    endcase
    return r;
  endfunction

  // Gauss-Legendre weights, Q0.24
  function automatic logic [WeightW-1:0] node_w(input logic [NodeBits-1:0] i);
    logic [WeightW-1:0] r;
    unique case (i)
      4'd0, 4'd15: r = 22'd455543;
      4'd1, 4'd14: r = 22'd1044441;
      4'd2, 4'd13: r = 22'd1596495;
      4'd3, 4'd12: r = 22'd2090927;
      4'd4, 4'd11: r = 22'd2509804;
      4'd5, 4'd10: r = 22'd2837975;
      4'd6, 4'd9:  r = 22'd3063577;
      4'd7, 4'd8:  r = 22'd3178454;
    endcase
    return r;
  endfunction

  // Bernstein derivative weights for one node, Q2.24
  function automatic coef_t node_coef(input logic [NodeBits-1:0] i);
    longint x;
    longint t;
    longint u;
    longint h;
    coef_t  r;
    x = longint'(node_x(i));
    t = (x + (64'sd1 <<< CoefBits)) >>> 1;
    u = (64'sd1 <<< CoefBits) - t;
    h = 64'sd1 <<< (CoefBits - 1);
    r.a = CoefW'((64'sd3 * u * u + h) >>> CoefBits);
    r.b = CoefW'((64'sd6 * u * t + h) >>> CoefBits);
    r.c = CoefW'((64'sd3 * t * t + h) >>> CoefBits);
    return r;
  endfunction

endpackage

FILE: src/bezier_arc_length.sv
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+-----------------------------------
// request  | in_p0_x .. in_p3_y (s32 each) | taken when start && !busy
// result   | out_arc_length (u36)          | out_valid strobe, one cycle
//
// A request occupies the node sequencer, which issues one quadrature node
// per cycle; busy is low while the last node is issued, so the next request
// can be taken in that cycle. After the last node the result strobe follows
// 4 derivative stages, 35 square root stages and 3 accumulate stages.
// Reset clears all valid bits and the sequencer. The receiver cannot stall.
module bezier_arc_length (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_p0_x,
  input  logic signed [31:0]    in_p0_y,
  input  logic signed [31:0]    in_p1_x,
  input  logic signed [31:0]    in_p1_y,
  input  logic signed [31:0]    in_p2_x,
  input  logic signed [31:0]    in_p2_y,
  input  logic signed [31:0]    in_p3_x,
  input  logic signed [31:0]    in_p3_y,
  output logic                  out_valid,
  output logic [35:0]           out_arc_length
);

  logic                               act_r;
  logic [bal_pkg::NodeBits-1:0]       cnt_r;
  logic                               accept;
  logic signed [bal_pkg::DiffW-1:0]   d1x_r, d2x_r, d3x_r, d1y_r, d2y_r, d3y_r;
  bal_pkg::tag_t                      issue;
  bal_pkg::tag_t                      dtag, stag;
  logic [bal_pkg::SqW-1:0]            sq_sum;
  logic [bal_pkg::RootW-1:0]          root;

  assign busy   = act_r && (cnt_r != bal_pkg::LastNode);
  assign accept = start && !busy;

  // step through the nodes of the current request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (accept) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == bal_pkg::LastNode) begin
        act_r <= 1'b0;
      end
    end
  end

  // hold control point differences
  always_ff @(posedge clk) begin
    if (accept) begin
      d1x_r <= 33'(in_p1_x) - 33'(in_p0_x);
      d2x_r <= 33'(in_p2_x) - 33'(in_p1_x);
      d3x_r <= 33'(in_p3_x) - 33'(in_p2_x);
      d1y_r <= 33'(in_p1_y) - 33'(in_p0_y);
      d2y_r <= 33'(in_p2_y) - 33'(in_p1_y);
      d3y_r <= 33'(in_p3_y) - 33'(in_p2_y);
    end
  end

  assign issue.vld  = act_r;
  assign issue.node = cnt_r;

  bal_deriv u_deriv (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_i    (issue),
    .d1x      (d1x_r),
    .d2x      (d2x_r),
    .d3x      (d3x_r),
    .d1y      (d1y_r),
    .d2y      (d2y_r),
    .d3y      (d3y_r),
    .tag_o    (dtag),
    .sq_sum_o (sq_sum)
  );

  bal_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (dtag),
    .num_i  (sq_sum),
    .tag_o  (stag),
    .root_o (root)
  );

  bal_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .tag_i          (stag),
    .root_i         (root),
    .out_valid      (out_valid),
    .out_arc_length (out_arc_length)
  );

endmodule

FILE: src/bal_deriv.sv
module bal_deriv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bal_pkg::tag_t                       tag_i,
  input  logic signed [bal_pkg::DiffW-1:0]    d1x,
  input  logic signed [bal_pkg::DiffW-1:0]    d2x,
  input  logic signed [bal_pkg::DiffW-1:0]    d3x,
  input  logic signed [bal_pkg::DiffW-1:0]    d1y,
  input  logic signed [bal_pkg::DiffW-1:0]    d2y,
  input  logic signed [bal_pkg::DiffW-1:0]    d3y,
  output bal_pkg::tag_t                       tag_o,
  output logic [bal_pkg::SqW-1:0]             sq_sum_o
);

  bal_pkg::coef_t coef;
  bal_pkg::tag_t  t1_r, t2_r, t3_r, t4_r;

  logic signed [bal_pkg::ProdW-1:0] px1_r, px2_r, px3_r, py1_r, py2_r, py3_r;
  logic signed [bal_pkg::SumW-1:0]  sx, sy;
  logic [bal_pkg::SumW-1:0]         ax, ay, rx, ry;
  logic [bal_pkg::MagW-1:0]         mx_r, my_r;
  logic [2*bal_pkg::MagW-1:0]       sqx_r, sqy_r;
  logic [bal_pkg::SqW-1:0]          sum_r;

  assign coef = bal_pkg::node_coef(tag_i.node);

  // advance valid tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
    end else begin
      t1_r <= tag_i;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
    end
  end

  // weight each difference by its node coefficient
  always_ff @(posedge clk) begin
    px1_r <= $signed({1'b0, coef.a}) * d1x;
    px2_r <= $signed({1'b0, coef.b}) * d2x;
    px3_r <= $signed({1'b0, coef.c}) * d3x;
    py1_r <= $signed({1'b0, coef.a}) * d1y;
    py2_r <= $signed({1'b0, coef.b}) * d2y;
    py3_r <= $signed({1'b0, coef.c}) * d3y;
  end

  // sum, take magnitude, round halves away from zero
  always_comb begin
    sx = 64'(px1_r) + 64'(px2_r) + 64'(px3_r);
    sy = 64'(py1_r) + 64'(py2_r) + 64'(py3_r);
    ax = sx[bal_pkg::SumW-1] ? 64'(-sx) : 64'(sx);
    ay = sy[bal_pkg::SumW-1] ? 64'(-sy) : 64'(sy);
    rx = ax + bal_pkg::RoundHalf;
    ry = ay + bal_pkg::RoundHalf;
  end

  always_ff @(posedge clk) begin
    mx_r  <= rx[bal_pkg::CoefBits +: bal_pkg::MagW];
    my_r  <= ry[bal_pkg::CoefBits +: bal_pkg::MagW];
    sqx_r <= mx_r * mx_r;
    sqy_r <= my_r * my_r;
    sum_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  assign tag_o    = t4_r;
  assign sq_sum_o = sum_r;

endmodule

FILE: src/bal_sqrt.sv
module bal_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bal_pkg::tag_t                tag_i,
  input  logic [bal_pkg::SqW-1:0]      num_i,
  output bal_pkg::tag_t                tag_o,
  output logic [bal_pkg::RootW-1:0]    root_o
);

  localparam int N = bal_pkg::SqrtSteps;

  bal_pkg::tag_t             tag_r [0:N];
  logic [bal_pkg::SqW-1:0]   num_r [0:N];
  logic [bal_pkg::SqW:0]     res_r [0:N];

  always_comb begin
    tag_r[0] = tag_i;
    num_r[0] = num_i;
    res_r[0] = '0;
  end

  // one root bit per stage, highest first
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [bal_pkg::SqW:0] Bit = (bal_pkg::SqW + 1)'(1) << (2 * (N - 1 - k));
    logic [bal_pkg::SqW:0] trial;
    logic                  ge;

    assign trial = res_r[k] + Bit;
    assign ge    = {1'b0, num_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1] <= '0;
      end else begin
        tag_r[k+1] <= tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      num_r[k+1] <= ge ? (num_r[k] - trial[bal_pkg::SqW-1:0]) : num_r[k];
      res_r[k+1] <= ge ? ((res_r[k] >> 1) + Bit) : (res_r[k] >> 1);
    end
  end

  assign tag_o  = tag_r[N];
  assign root_o = res_r[N][bal_pkg::RootW-1:0];

endmodule

FILE: src/bal_accum.sv
module bal_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bal_pkg::tag_t                tag_i,
  input  logic [bal_pkg::RootW-1:0]    root_i,
  output logic                         out_valid,
  output logic [bal_pkg::OutW-1:0]     out_arc_length
);

  bal_pkg::tag_t                tw_r;
  logic [bal_pkg::WProdW-1:0]   prod_r;
  logic [bal_pkg::AccW-1:0]     acc_r, acc_nxt;
  logic                         done_r;
  logic                         out_valid_r;
  logic [bal_pkg::OutW-1:0]     out_len_r;
  logic [bal_pkg::AccW-1:0]     rnd;
  logic [bal_pkg::AccW-bal_pkg::CoefBits-2:0] half;

  // weight the magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= '0;
    end else begin
      tw_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= bal_pkg::WProdW'(bal_pkg::node_w(tag_i.node)) * bal_pkg::WProdW'(root_i);
  end

  // restart the sum at the first node of each curve
  always_comb begin
    acc_nxt = acc_r;
    if (tw_r.vld) begin
      if (tw_r.node == '0) begin
        acc_nxt = 64'(prod_r);
      end else begin
        acc_nxt = acc_r + 64'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= tw_r.vld && (tw_r.node == bal_pkg::LastNode);
    end
  end

  // halve, round and saturate
  assign rnd  = acc_r + bal_pkg::OutRound;
  assign half = rnd[bal_pkg::AccW-1:bal_pkg::CoefBits+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (half > {{(bal_pkg::AccW-bal_pkg::CoefBits-1-bal_pkg::OutW){1'b0}}, bal_pkg::OutMax}) begin
      out_len_r <= bal_pkg::OutMax;
    end else begin
      out_len_r <= half[bal_pkg::OutW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_arc_length = out_len_r;

endmodule
